/* hw/rtl/ffca_pkg.sv */
// Shared types and constants of the first-fit chunk allocator.
package ffca_pkg;

    localparam int MAX_CHUNKS  = 1024;
    localparam int CHUNK_SHIFT = 5;
    localparam int CHUNK_BYTES = 1 << CHUNK_SHIFT;
    localparam int HDR_BYTES   = 16;
    localparam int AW          = $clog2(MAX_CHUNKS);  // chunk index width
    localparam int LW          = AW + 1;              // block length width
    localparam int IW          = AW + 2;              // walk index width, holds index + length
    localparam int OFF_W       = 15;
    localparam int SIZE_W      = 15;
    localparam int TOT_W       = 16;

    typedef enum logic [1:0] {
        OP_ALLOC   = 2'd0,
        OP_FREE    = 2'd1,
        OP_REALLOC = 2'd2,
        OP_REINIT  = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_BAD_PAR = 2'd1,
        ST_NO_MEM  = 2'd2,
        ST_BAD_PTR = 2'd3
    } t_status;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_CHK_RD,
        S_CHK,
        S_ABS_RD,
        S_ABS,
        S_ABS_END,
        S_MERGE_RD,
        S_MERGE,
        S_WALK_RD,
        S_WALK,
        S_SPLIT1,
        S_SPLIT2,
        S_DONE
    } t_state;

    // One entry of the chunk table.
    typedef struct packed {
        logic          hv;
        logic          used;
        logic [LW-1:0] len;
    } t_entry;

    typedef struct packed {
        logic          we;
        logic [AW-1:0] waddr;
        t_entry        wdata;
        logic [AW-1:0] raddr;
    } t_mem_req;

    typedef struct packed {
        t_status            status;
        logic [OFF_W-1:0]   offset;
        logic [TOT_W-1:0]   used;
    } t_result;

endpackage

/* hw/rtl/ffca_mem.sv */
// Chunk table memory: one write port, one registered read port.
module ffca_mem
    import ffca_pkg::*;
(
    input  logic     i_clk,
    input  t_mem_req i_req,
    output t_entry   o_rdata
);

    t_entry mem [MAX_CHUNKS];
    t_entry r_rdata;

    // Write and registered read.
    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            mem[i_req.waddr] <= i_req.wdata;
        end
        r_rdata <= mem[i_req.raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* hw/rtl/ffca_ctrl.sv */
// Sequencer and shared datapath that walk, split and merge blocks in the chunk table.
module ffca_ctrl
    import ffca_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [LW-1:0]     i_cfg_wdata,
    input  logic              i_in_valid,
    input  logic [1:0]        i_operation,
    input  logic [SIZE_W-1:0] i_size_bytes,
    input  logic [OFF_W-1:0]  i_user_offset,
    input  logic              i_slot_free,
    input  t_entry            i_rdata,
    output logic              o_in_ready,
    output logic              o_done,
    output t_result           o_result,
    output t_mem_req          o_mem
);

    t_state r_state, n_state;
    t_op    r_op, n_op;
    logic [SIZE_W-1:0] r_size, n_size;
    logic [OFF_W-1:0]  r_ptr, n_ptr;
    logic [LW-1:0]     r_need, n_need;
    logic [IW-1:0]     r_i, n_i;
    logic [AW-1:0]     r_h, n_h;
    logic [LW-1:0]     r_hlen, n_hlen;
    logic [IW-1:0]     r_nx, n_nx;
    logic [TOT_W-1:0]  r_total, n_total;
    t_status           r_status, n_status;
    logic [OFF_W-1:0]  r_off, n_off;
    logic [LW-1:0]     r_pool, n_pool;
    logic [AW-1:0]     r_clr, n_clr;
    logic              r_item, n_item;
    logic              r_merge, n_merge;

    logic [LW-1:0]     live;
    logic [TOT_W-1:0]  need_sum;
    logic [LW-1:0]     need_in;
    logic [OFF_W-1:0]  ptr_q;
    logic [OFF_W-1:0]  ptr_h;
    logic              ptr_ok;
    logic              in_acc;
    t_op               op_in;
    logic              realloc_fits;
    logic              absorb_ok;
    logic              entry_free;
    logic              walk_fits;

    // Effective pool size, clamped to the table.
    always_comb begin
        if (r_pool < LW'(2)) begin
            live = LW'(2);
        end else if (r_pool > LW'(MAX_CHUNKS)) begin
            live = LW'(MAX_CHUNKS);
        end else begin
            live = r_pool;
        end
    end

    // Request decode: chunk count and header position of a user pointer.
    assign op_in    = t_op'(i_operation);
    assign in_acc   = o_in_ready && i_in_valid;
    assign need_sum = TOT_W'(i_size_bytes) + TOT_W'(CHUNK_BYTES + HDR_BYTES);
    assign need_in  = LW'(need_sum >> CHUNK_SHIFT);
    assign ptr_q    = i_user_offset - OFF_W'(HDR_BYTES);
    assign ptr_h    = ptr_q >> CHUNK_SHIFT;
    assign ptr_ok   = (i_user_offset >= OFF_W'(HDR_BYTES))
                   && (ptr_q[CHUNK_SHIFT-1:0] == '0)
                   && (ptr_h < OFF_W'(live));

    // Entry tests on the word just read.
    assign entry_free   = i_rdata.hv && !i_rdata.used;
    assign absorb_ok    = entry_free && (i_rdata.len != '0);
    assign walk_fits    = entry_free && (i_rdata.len > r_need);
    assign realloc_fits = (TOT_W'(r_size) + TOT_W'(HDR_BYTES))
                       <= (TOT_W'(i_rdata.len) << CHUNK_SHIFT);

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_CLEAR: begin
                if (r_clr == AW'(MAX_CHUNKS - 1)) begin
                    n_state = r_item ? S_DONE : S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_cfg_we) begin
                    n_state = S_CLEAR;
                end else if (i_in_valid) begin
                    case (op_in)
                        OP_ALLOC:   n_state = (i_size_bytes == '0) ? S_DONE : S_WALK_RD;
                        OP_REINIT:  n_state = S_CLEAR;
                        default:    n_state = ptr_ok ? S_CHK_RD : S_DONE;
                    endcase
                end
            end
            S_CHK_RD: n_state = S_CHK;
            S_CHK: begin
                if (!i_rdata.hv || !i_rdata.used) begin
                    n_state = S_DONE;
                end else if (r_op == OP_REALLOC && realloc_fits) begin
                    n_state = S_DONE;
                end else begin
                    n_state = S_ABS_RD;
                end
            end
            S_ABS_RD:  n_state = (r_nx < IW'(live)) ? S_ABS : S_ABS_END;
            S_ABS:     n_state = absorb_ok ? S_ABS_RD : S_ABS_END;
            S_ABS_END: begin
                if (r_merge) begin
                    n_state = S_MERGE_RD;
                end else begin
                    n_state = (r_op == OP_REALLOC) ? S_WALK_RD : S_DONE;
                end
            end
            S_MERGE_RD: n_state = (r_i < IW'(live)) ? S_MERGE : S_DONE;
            S_MERGE: begin
                if (i_rdata.len == '0) begin
                    n_state = S_DONE;
                end else if (entry_free) begin
                    n_state = S_ABS_RD;
                end else begin
                    n_state = S_MERGE_RD;
                end
            end
            S_WALK_RD: n_state = (r_i < IW'(live)) ? S_WALK : S_MERGE_RD;
            S_WALK: begin
                if (i_rdata.len == '0) begin
                    n_state = S_MERGE_RD;
                end else if (walk_fits) begin
                    n_state = S_SPLIT1;
                end else begin
                    n_state = S_WALK_RD;
                end
            end
            S_SPLIT1: n_state = S_SPLIT2;
            S_SPLIT2: n_state = S_DONE;
            S_DONE:   n_state = i_slot_free ? S_IDLE : S_DONE;
            default:  n_state = S_CLEAR;
        endcase
    end

    // Outputs: handshake and memory port.
    always_comb begin
        o_in_ready      = (r_state == S_IDLE) && !i_cfg_we;
        o_done          = (r_state == S_DONE);
        o_mem.we        = 1'b0;
        o_mem.waddr     = r_h;
        o_mem.wdata     = '0;
        o_mem.raddr     = r_i[AW-1:0];
        unique case (r_state)
            S_CLEAR: begin
                o_mem.we    = 1'b1;
                o_mem.waddr = r_clr;
                if (r_clr == '0) begin
                    o_mem.wdata = '{hv: 1'b1, used: 1'b0, len: live};
                end
            end
            S_CHK_RD: o_mem.raddr = r_h;
            S_ABS_RD: o_mem.raddr = r_nx[AW-1:0];
            S_ABS: begin
                o_mem.we    = absorb_ok;
                o_mem.waddr = r_nx[AW-1:0];
            end
            S_ABS_END: begin
                o_mem.we    = 1'b1;
                o_mem.wdata = '{hv: 1'b1, used: 1'b0, len: r_hlen};
            end
            S_SPLIT1: begin
                o_mem.we    = 1'b1;
                o_mem.wdata = '{hv: 1'b1, used: 1'b1, len: r_need};
            end
            S_SPLIT2: begin
                o_mem.we    = 1'b1;
                o_mem.waddr = r_i[AW-1:0];
                o_mem.wdata = '{hv: 1'b1, used: 1'b0, len: r_hlen};
            end
            default: begin
            end
        endcase
    end

    // Datapath next values, sharing one index adder path per state.
    always_comb begin
        n_op     = r_op;
        n_size   = r_size;
        n_ptr    = r_ptr;
        n_need   = r_need;
        n_i      = r_i;
        n_h      = r_h;
        n_hlen   = r_hlen;
        n_nx     = r_nx;
        n_total  = r_total;
        n_status = r_status;
        n_off    = r_off;
        n_pool   = r_pool;
        n_clr    = r_clr;
        n_item   = r_item;
        n_merge  = r_merge;
        case (r_state)
            S_CLEAR: n_clr = r_clr + AW'(1);
            S_IDLE: begin
                if (i_cfg_we) begin
                    n_pool  = i_cfg_wdata;
                    n_total = '0;
                    n_clr   = '0;
                    n_item  = 1'b0;
                end else if (in_acc) begin
                    n_op     = op_in;
                    n_size   = i_size_bytes;
                    n_ptr    = i_user_offset;
                    n_need   = need_in;
                    n_status = ST_OK;
                    n_off    = '0;
                    n_i      = '0;
                    n_merge  = 1'b0;
                    n_h      = ptr_h[AW-1:0];
                    case (op_in)
                        OP_ALLOC: begin
                            if (i_size_bytes == '0) begin
                                n_status = ST_BAD_PAR;
                            end
                        end
                        OP_REINIT: begin
                            n_total = '0;
                            n_clr   = '0;
                            n_item  = 1'b1;
                        end
                        default: begin
                            if (!ptr_ok) begin
                                n_status = ST_BAD_PTR;
                            end
                        end
                    endcase
                end
            end
            S_CHK: begin
                if (!i_rdata.hv || !i_rdata.used) begin
                    n_status = ST_BAD_PTR;
                end else if (r_op == OP_REALLOC && realloc_fits) begin
                    n_off = r_ptr;
                end else begin
                    n_total = r_total - (TOT_W'(i_rdata.len) << CHUNK_SHIFT);
                    n_hlen  = i_rdata.len;
                    n_nx    = IW'(r_h) + IW'(i_rdata.len);
                end
            end
            S_ABS: begin
                if (absorb_ok) begin
                    n_hlen = r_hlen + i_rdata.len;
                    n_nx   = IW'(r_h) + IW'(r_hlen + i_rdata.len);
                end
            end
            S_ABS_END: begin
                n_i = r_merge ? (IW'(r_h) + IW'(r_hlen)) : '0;
            end
            S_MERGE: begin
                if (i_rdata.len != '0) begin
                    if (entry_free) begin
                        n_h    = r_i[AW-1:0];
                        n_hlen = i_rdata.len;
                        n_nx   = r_i + IW'(i_rdata.len);
                    end else begin
                        n_i = r_i + IW'(i_rdata.len);
                    end
                end
            end
            S_WALK_RD: begin
                if (!(r_i < IW'(live))) begin
                    n_status = ST_NO_MEM;
                    n_i      = '0;
                    n_merge  = 1'b1;
                end
            end
            S_WALK: begin
                if (i_rdata.len == '0) begin
                    n_status = ST_NO_MEM;
                    n_i      = '0;
                    n_merge  = 1'b1;
                end else if (walk_fits) begin
                    n_h    = AW'(r_i + IW'(i_rdata.len) - IW'(r_need));
                    n_hlen = i_rdata.len - r_need;
                end else begin
                    n_i = r_i + IW'(i_rdata.len);
                end
            end
            S_SPLIT2: begin
                n_total = r_total + (TOT_W'(r_need) << CHUNK_SHIFT);
                n_off   = OFF_W'((OFF_W'(r_h) << CHUNK_SHIFT) + OFF_W'(HDR_BYTES));
            end
            default: begin
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_pool  <= LW'(MAX_CHUNKS);
            r_clr   <= '0;
            r_item  <= 1'b0;
            r_total <= '0;
            r_merge <= 1'b0;
        end else begin
            r_state <= n_state;
            r_pool  <= n_pool;
            r_clr   <= n_clr;
            r_item  <= n_item;
            r_total <= n_total;
            r_merge <= n_merge;
        end
    end

    // Working registers.
    always_ff @(posedge i_clk) begin
        r_op     <= n_op;
        r_size   <= n_size;
        r_ptr    <= n_ptr;
        r_need   <= n_need;
        r_i      <= n_i;
        r_h      <= n_h;
        r_hlen   <= n_hlen;
        r_nx     <= n_nx;
        r_status <= n_status;
        r_off    <= n_off;
    end

    assign o_result = '{status: r_status, offset: r_off, used: r_total};

`ifndef SYNTHESIS
    // The tail write of a split always follows its header write.
    a_split_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_SPLIT2 |-> $past(r_state) == S_SPLIT1)
        else $error("split tail write without header write");

    // Outside the clearing pass, writes stay inside the live pool.
    a_write_in_pool: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_mem.we && r_state != S_CLEAR) |-> (IW'(o_mem.waddr) < IW'(live)))
        else $error("table write outside the pool");

    // An allocation walk never runs with a zero chunk count.
    a_need_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_WALK |-> r_need != '0)
        else $error("walk with zero chunk count");
`endif

endmodule

/* hw/rtl/first_fit_chunk_allocator.sv */
// Flow per request: zero size or a bad pointer range answers without reading the table; free
// and reallocate read and check the header first, and a fitting reallocate answers there. Free
// then absorbs the free blocks that follow. Allocate walks blocks until one fits; a miss then
// runs a merge sweep over the pool. A moving reallocate is a free plus an allocate, and
// reinitialize clears the whole table before it answers.
// One request at a time; reset (sync, active low) restores 1024 chunks and clears the table.
module first_fit_chunk_allocator
    import ffca_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [LW-1:0]     i_cfg_wdata,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  logic [1:0]        i_operation,
    input  logic [SIZE_W-1:0] i_size_bytes,
    input  logic [OFF_W-1:0]  i_user_offset,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output logic [1:0]        o_status,
    output logic [OFF_W-1:0]  o_result_offset,
    output logic [TOT_W-1:0]  o_used_bytes
);

    t_mem_req mem_req;
    t_entry   rdata;
    t_result  result;
    logic     done;
    logic     slot_free;
    logic     r_out_valid;
    t_result  r_out;

    ffca_mem u_mem (
        .i_clk   (i_clk),
        .i_req   (mem_req),
        .o_rdata (rdata)
    );

    ffca_ctrl u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .i_in_valid    (i_in_valid),
        .i_operation   (i_operation),
        .i_size_bytes  (i_size_bytes),
        .i_user_offset (i_user_offset),
        .i_slot_free   (slot_free),
        .i_rdata       (rdata),
        .o_in_ready    (o_in_ready),
        .o_done        (done),
        .o_result      (result),
        .o_mem         (mem_req)
    );

    // Output register decouples the result from the next request.
    assign slot_free = !r_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (done && slot_free) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (done && slot_free) begin
            r_out <= result;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_status        = r_out.status;
    assign o_result_offset = r_out.offset;
    assign o_used_bytes    = r_out.used;

endmodule

/* verif/tb_first_fit_chunk_allocator.sv */
// Self-checking testbench for the first-fit chunk allocator with its own pool predictor.
`timescale 1ns / 1ps

module tb_first_fit_chunk_allocator;
    import ffca_pkg::*;

    // Expected response of one request.
    typedef struct packed {
        logic [1:0]        status;
        logic [OFF_W-1:0]  offset;
        logic [TOT_W-1:0]  used;
    } t_expect;

    // Scoreboard: a software copy of the chunk table predicts every response.
    class pool_scoreboard;
        bit              hdr[MAX_CHUNKS];
        int unsigned     blen[MAX_CHUNKS];
        int unsigned     req_size[MAX_CHUNKS];
        int unsigned     pool_reg;
        int unsigned     total;
        t_expect         pending[$];
        int              errors;

        function int unsigned pool_len();
            int unsigned n;
            n = pool_reg;
            if (n < 2) n = 2;
            if (n > MAX_CHUNKS) n = MAX_CHUNKS;
            return n;
        endfunction

        function void format();
            for (int i = 0; i < MAX_CHUNKS; i++) begin
                hdr[i] = 0;
                blen[i] = 0;
                req_size[i] = 0;
            end
            hdr[0] = 1;
            blen[0] = pool_len();
            total = 0;
        endfunction

        function void set_pool(int unsigned v);
            pool_reg = v & 11'h7FF;
            format();
        endfunction

        // Fold the free blocks that follow a free block into it.
        function void absorb(int unsigned h);
            int unsigned n;
            int unsigned nx;
            n = pool_len();
            if (h >= n || !hdr[h] || req_size[h] != 0) return;
            nx = h + blen[h];
            while (nx < n && hdr[nx] && req_size[nx] == 0 && blen[nx] != 0) begin
                blen[h] += blen[nx];
                hdr[nx] = 0;
                blen[nx] = 0;
                nx = h + blen[h];
            end
        endfunction

        function void merge_all();
            int unsigned i;
            i = 0;
            while (i < pool_len() && blen[i] != 0) begin
                absorb(i);
                i += blen[i];
            end
        endfunction

        function logic [1:0] alloc(int unsigned size, output int unsigned off);
            int unsigned need;
            int unsigned i;
            int unsigned h;
            off = 0;
            if (size == 0) return ST_BAD_PAR;
            need = ((size + CHUNK_BYTES + HDR_BYTES) & ~(CHUNK_BYTES - 1)) >> CHUNK_SHIFT;
            i = 0;
            while (i < pool_len() && blen[i] != 0) begin
                if (hdr[i] && req_size[i] == 0 && blen[i] > need) begin
                    h = i + blen[i] - need;
                    hdr[h] = 1;
                    blen[h] = need;
                    req_size[h] = size;
                    blen[i] -= need;
                    total = (total + (need << CHUNK_SHIFT)) & 16'hFFFF;
                    off = ((h << CHUNK_SHIFT) + HDR_BYTES) & 15'h7FFF;
                    return ST_OK;
                end
                i += blen[i];
            end
            merge_all();
            return ST_NO_MEM;
        endfunction

        function bit locate(int unsigned p, output int unsigned h);
            int unsigned q;
            h = 0;
            if (p < HDR_BYTES) return 0;
            q = p - HDR_BYTES;
            if ((q & (CHUNK_BYTES - 1)) != 0) return 0;
            h = q >> CHUNK_SHIFT;
            if (h >= pool_len()) return 0;
            if (!hdr[h] || req_size[h] == 0) return 0;
            return 1;
        endfunction

        function void release_block(int unsigned h);
            req_size[h] = 0;
            total = (total - (blen[h] << CHUNK_SHIFT)) & 16'hFFFF;
            absorb(h);
        endfunction

        // Note an accepted request and queue its expected response.
        function void note_request(logic [1:0] op, int unsigned size, int unsigned p);
            t_expect e;
            int unsigned off;
            int unsigned h;
            logic [1:0] st;
            st = ST_OK;
            off = 0;
            case (op)
                OP_ALLOC: st = alloc(size, off);
                OP_FREE: begin
                    if (locate(p, h)) release_block(h);
                    else st = ST_BAD_PTR;
                end
                OP_REALLOC: begin
                    if (!locate(p, h)) st = ST_BAD_PTR;
                    else if (size + HDR_BYTES <= (blen[h] << CHUNK_SHIFT)) off = p;
                    else begin
                        release_block(h);
                        st = alloc(size, off);
                    end
                end
                default: format();
            endcase
            e.status = st;
            e.offset = off[OFF_W-1:0];
            e.used = total[TOT_W-1:0];
            pending.push_back(e);
        endfunction

        // Compare one response against the oldest expectation.
        function void check_response(logic [1:0] st, logic [OFF_W-1:0] off,
                                     logic [TOT_W-1:0] used);
            t_expect e;
            if (pending.size() == 0) begin
                $display("%0t: unexpected response status=%0d offset=%0d used=%0d",
                         $time, st, off, used);
                errors++;
                return;
            end
            e = pending.pop_front();
            if (st !== e.status) begin
                $display("%0t: status expected %0d actual %0d", $time, e.status, st);
                errors++;
            end
            if (off !== e.offset) begin
                $display("%0t: offset expected %0d actual %0d", $time, e.offset, off);
                errors++;
            end
            if (used !== e.used) begin
                $display("%0t: used expected %0d actual %0d", $time, e.used, used);
                errors++;
            end
        endfunction
    endclass

    logic              i_clk = 0;
    logic              i_rst_n = 0;
    logic              i_cfg_we = 0;
    logic [LW-1:0]     i_cfg_wdata = '0;
    logic              i_in_valid = 0;
    logic              o_in_ready;
    logic [1:0]        i_operation = OP_ALLOC;
    logic [SIZE_W-1:0] i_size_bytes = '0;
    logic [OFF_W-1:0]  i_user_offset = '0;
    logic              o_out_valid;
    logic              i_out_ready = 0;
    logic [1:0]        o_status;
    logic [OFF_W-1:0]  o_result_offset;
    logic [TOT_W-1:0]  o_used_bytes;

    pool_scoreboard sb;
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int unsigned live_offs[$];

    first_fit_chunk_allocator dut (.*);

    always begin
        #5 i_clk = 1;
        #5 i_clk = 0;
    end

    // Response side: random stalls, check on each accepted response.
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            sb.check_response(o_status, o_result_offset, o_used_bytes);
        end
        i_out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Send one request, with random idle cycles before it.
    task automatic send_request(logic [1:0] op, int unsigned size, int unsigned p);
        while ($urandom_range(99) < send_idle_pct) @(posedge i_clk);
        i_in_valid <= 1;
        i_operation <= op;
        i_size_bytes <= size[SIZE_W-1:0];
        i_user_offset <= p[OFF_W-1:0];
        do @(posedge i_clk); while (!o_in_ready);
        sb.note_request(op, size, p);
        i_in_valid <= 0;
        if (op == OP_ALLOC || op == OP_REALLOC) begin
            if (sb.pending[$].status == ST_OK) live_offs.push_back(sb.pending[$].offset);
        end
        // The block is busy after accepting a request, so this wait costs no rate.
        @(posedge i_clk);
    endtask

    task automatic drain();
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (1100) @(posedge i_clk);
    endtask

    // Write the pool size while the block is idle.
    task automatic write_pool(int unsigned v);
        drain();
        i_cfg_we <= 1;
        i_cfg_wdata <= v[LW-1:0];
        @(posedge i_clk);
        i_cfg_we <= 0;
        sb.set_pool(v);
        live_offs.delete();
    endtask

    // Pick a request: mostly sensible sizes and live pointers, some noise.
    task automatic random_request();
        int unsigned r;
        int unsigned sz;
        int unsigned p;
        int k;
        r = $urandom_range(99);
        sz = ($urandom_range(9) == 0) ? $urandom_range(32767) : $urandom_range(600);
        p = $urandom_range(32767);
        if (live_offs.size() != 0 && $urandom_range(9) < 8) begin
            k = $urandom_range(live_offs.size() - 1);
            p = live_offs[k];
            if (r >= 45 && r < 80) live_offs.delete(k);
        end
        if (r < 45) send_request(OP_ALLOC, sz, p);
        else if (r < 75) send_request(OP_FREE, sz, p);
        else if (r < 98) send_request(OP_REALLOC, sz, p);
        else begin
            send_request(OP_REINIT, sz, p);
            live_offs.delete();
        end
    endtask

    initial begin
        sb = new();
        sb.set_pool(1024);
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1;

        // Directed: extremes, every operation, bad parameter and bad pointers.
        send_request(OP_ALLOC, 0, 0);
        send_request(OP_ALLOC, 1, 0);
        send_request(OP_ALLOC, 32767, 0);
        send_request(OP_ALLOC, 100, 0);
        send_request(OP_REALLOC, 0, live_offs[0]);
        send_request(OP_REALLOC, 2000, live_offs[0]);
        send_request(OP_FREE, 0, 0);
        send_request(OP_FREE, 0, 17);
        send_request(OP_FREE, 0, 32767);
        send_request(OP_FREE, 0, live_offs[1]);
        send_request(OP_FREE, 0, live_offs[1]);
        send_request(OP_REALLOC, 5, 48);
        send_request(OP_REINIT, 32767, 32767);
        live_offs.delete();

        write_pool(0);
        send_request(OP_ALLOC, 1, 0);
        send_request(OP_ALLOC, 16, 0);
        send_request(OP_ALLOC, 15, 0);
        write_pool(2047);
        send_request(OP_ALLOC, 32767, 0);
        send_request(OP_ALLOC, 32000, 0);

        // Random phases across pool sizes and idling patterns.
        for (int ph = 0; ph < 8; ph++) begin
            write_pool((ph % 4 == 0) ? 1024 : (ph % 4 == 1) ? 2 : $urandom_range(3, 64));
            case (ph % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 71; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 71; end
                default: begin send_idle_pct = 32; recv_stall_pct = 32; end
            endcase
            repeat (70) random_request();
        end

        drain();
        if (sb.errors == 0) $display("TB_OK");
        else $display("TB_ERROR");
        $finish;
    end

    initial begin
        #60ms;
        $display("TB_ERROR");
        $finish;
    end

endmodule

/* sim.f */
hw/rtl/ffca_pkg.sv
hw/rtl/ffca_mem.sv
hw/rtl/ffca_ctrl.sv
hw/rtl/first_fit_chunk_allocator.sv
verif/tb_first_fit_chunk_allocator.sv
